[src/kfi_pkg.sv]
`timescale 1ns / 1ps

package kfi_pkg;

	typedef enum logic [2:0] {
		PH_DISABLED  = 3'd0,
		PH_LOW       = 3'd1,
		PH_HIGH      = 3'd2,
		PH_WAITING   = 3'd3,
		PH_FAILED    = 3'd4,
		PH_CONNECTED = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ACT_NONE = 3'd0,
		ACT_LOW  = 3'd1,
		ACT_HIGH = 3'd2,
		ACT_SEND = 3'd3,
		ACT_STOP = 3'd4
	} action_t;

	localparam logic [1:0] FN_START = 2'd0;
	localparam logic [1:0] FN_TICK  = 2'd1;
	localparam logic [1:0] FN_BYTE  = 2'd2;

	localparam logic [2:0] CFG_ENABLE   = 3'd0;
	localparam logic [2:0] CFG_ECHO_ON  = 3'd1;
	localparam logic [2:0] CFG_LOW_MS   = 3'd2;
	localparam logic [2:0] CFG_HIGH_MS  = 3'd3;
	localparam logic [2:0] CFG_LATE_MS  = 3'd4;
	localparam logic [2:0] CFG_RESP_MS  = 3'd5;

	localparam logic [7:0]  RST_LOW_MS  = 8'd25;
	localparam logic [7:0]  RST_HIGH_MS = 8'd25;
	localparam logic [7:0]  RST_LATE_MS = 8'd10;
	localparam logic [15:0] RST_RESP_MS = 16'd1000;

	localparam logic [2:0] MSG_LEN  = 3'd5;
	localparam logic [2:0] LAST_IDX = 3'd4;

	typedef struct packed {
		logic        enable;
		logic        echo_on;
		logic [7:0]  low_ms;
		logic [7:0]  high_ms;
		logic [7:0]  late_ms;
		logic [15:0] resp_ms;
	} cfg_t;

	typedef struct packed {
		action_t action;
		logic    accepted;
		phase_t  phase;
	} res_t;

	function automatic logic [7:0] echo_byte(input logic [2:0] idx);
		case (idx)
			3'd0: return 8'h81;
			3'd1: return 8'h13;
			3'd2: return 8'hF7;
			3'd3: return 8'h81;
			3'd4: return 8'h0C;
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] reply_byte(input logic [2:0] idx);
		case (idx)
			3'd0: return 8'h03;
			3'd1: return 8'hC1;
			3'd2: return 8'hD5;
			3'd3: return 8'h8F;
			3'd4: return 8'h28;
			default: return 8'h00;
		endcase
	endfunction

endpackage

[src/kfi_cfg.sv]
`timescale 1ns / 1ps

module kfi_cfg (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [2:0]   wr_index,
	input  logic [15:0]  wr_data,
	output kfi_pkg::cfg_t cfg
);
	import kfi_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable  <= 1'b0;
			cfg_q.echo_on <= 1'b0;
			cfg_q.low_ms  <= RST_LOW_MS;
			cfg_q.high_ms <= RST_HIGH_MS;
			cfg_q.late_ms <= RST_LATE_MS;
			cfg_q.resp_ms <= RST_RESP_MS;
		end else if (wr_en) begin
			case (wr_index)
				CFG_ENABLE:  cfg_q.enable  <= wr_data[0];
				CFG_ECHO_ON: cfg_q.echo_on <= wr_data[0];
				CFG_LOW_MS:  cfg_q.low_ms  <= wr_data[7:0];
				CFG_HIGH_MS: cfg_q.high_ms <= wr_data[7:0];
				CFG_LATE_MS: cfg_q.late_ms <= wr_data[7:0];
				CFG_RESP_MS: cfg_q.resp_ms <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/kfi_core.sv]
`timescale 1ns / 1ps

module kfi_core #(
	parameter int TIME_BITS = 40
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [1:0]           func,
	input  logic [TIME_BITS-1:0] now,
	input  logic [7:0]           rx,
	input  kfi_pkg::cfg_t        cfg,
	output kfi_pkg::res_t        res
);
	import kfi_pkg::*;

	phase_t               phase_q, phase_d;
	logic [2:0]           echo_cnt_q, echo_cnt_d;
	logic [2:0]           reply_cnt_q, reply_cnt_d;
	logic                 echo_latch_q, echo_latch_d;
	logic [TIME_BITS-1:0] deadline_q, deadline_d;

	logic [15:0]          span;
	logic [TIME_BITS:0]   sum;
	logic [TIME_BITS-1:0] later_t;
	logic [TIME_BITS-1:0] diff;
	logic                 due, late, echo_phase, reply_phase, echo_ok, reply_ok;
	action_t              action;
	logic                 accepted;

	// one shared adder for every new deadline, saturating at the top of the time range
	always_comb begin
		if (func == FN_START)
			span = {8'd0, cfg.low_ms};
		else if (phase_q == PH_LOW)
			span = {8'd0, cfg.high_ms};
		else
			span = cfg.resp_ms;
	end

	assign sum     = {1'b0, now} + {{(TIME_BITS-15){1'b0}}, span};
	assign later_t = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];

	assign due         = now >= deadline_q;
	assign diff        = now - deadline_q;
	assign late        = diff > {{(TIME_BITS-8){1'b0}}, cfg.late_ms};
	assign echo_phase  = echo_latch_q && (echo_cnt_q < MSG_LEN);
	assign reply_phase = reply_cnt_q < MSG_LEN;
	assign echo_ok     = rx == echo_byte(echo_cnt_q);
	assign reply_ok    = rx == reply_byte(reply_cnt_q);

	// next state
	always_comb begin
		phase_d      = phase_q;
		echo_cnt_d   = echo_cnt_q;
		reply_cnt_d  = reply_cnt_q;
		echo_latch_d = echo_latch_q;
		deadline_d   = deadline_q;
		case (func)
			FN_START: begin
				echo_latch_d = cfg.echo_on;
				echo_cnt_d   = 3'd0;
				reply_cnt_d  = 3'd0;
				deadline_d   = later_t;
				phase_d      = cfg.enable ? PH_LOW : PH_DISABLED;
			end
			FN_TICK: begin
				if ((phase_q == PH_LOW || phase_q == PH_HIGH) && due) begin
					if (late) begin
						phase_d = PH_FAILED;
					end else if (phase_q == PH_LOW) begin
						phase_d    = PH_HIGH;
						deadline_d = later_t;
					end else begin
						phase_d    = PH_WAITING;
						deadline_d = later_t;
					end
				end else if (phase_q == PH_WAITING && due) begin
					phase_d = PH_FAILED;
				end
			end
			FN_BYTE: begin
				if (phase_q == PH_WAITING) begin
					if (due) begin
						phase_d = PH_FAILED;
					end else if (echo_phase) begin
						if (!echo_ok)
							phase_d = PH_FAILED;
						echo_cnt_d = echo_cnt_q + 3'd1;
					end else if (reply_phase) begin
						reply_cnt_d = reply_cnt_q + 3'd1;
						if (!reply_ok)
							phase_d = PH_FAILED;
						else if (reply_cnt_q == LAST_IDX)
							phase_d = PH_CONNECTED;
					end
				end
			end
			default: ;
		endcase
	end

	// outputs
	always_comb begin
		action   = ACT_NONE;
		accepted = 1'b0;
		case (func)
			FN_START: begin
				if (cfg.enable)
					action = ACT_LOW;
			end
			FN_TICK: begin
				if ((phase_q == PH_LOW || phase_q == PH_HIGH) && due) begin
					if (late)
						action = ACT_STOP;
					else if (phase_q == PH_LOW)
						action = ACT_HIGH;
					else
						action = ACT_SEND;
				end else if (phase_q == PH_WAITING && due) begin
					action = ACT_STOP;
				end
			end
			FN_BYTE: begin
				if (phase_q == PH_WAITING && !due) begin
					if (echo_phase)
						accepted = echo_ok;
					else if (reply_phase)
						accepted = reply_ok;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_DISABLED;
			echo_cnt_q   <= 3'd0;
			reply_cnt_q  <= 3'd0;
			echo_latch_q <= 1'b0;
			deadline_q   <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			echo_cnt_q   <= echo_cnt_d;
			reply_cnt_q  <= reply_cnt_d;
			echo_latch_q <= echo_latch_d;
			deadline_q   <= deadline_d;
		end
	end

	assign res.action   = action;
	assign res.accepted = accepted;
	assign res.phase    = phase_d;

endmodule

[src/kline_fast_init_handshake.sv]
`timescale 1ns / 1ps
// a taken word is held in the input register, and its result word then in the result register
// one word per cycle while out_stall is low; input register and result register stall together
// in_stall rises only while a result word is held and the input register is full
// reset (arst_n low): disabled phase, counters and deadline cleared, registers at defaults
// configuration writes always ready, applied at the next edge

module kline_fast_init_handshake #(
	parameter int TIME_BITS = 40
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           func,
	input  logic [TIME_BITS-1:0] now_ms,
	input  logic [7:0]           rx_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           line_action,
	output logic                 byte_accepted,
	output logic [2:0]           link_state,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_data
);
	import kfi_pkg::*;

	logic                 valid_s1;
	logic [1:0]           func_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic [7:0]           rx_s1;

	logic                 valid_s2;
	res_t                 res_s2;

	logic                 advance, load_s1, step;
	cfg_t                 cfg;
	res_t                 res;

	assign cfg_ready = 1'b1;
	assign advance   = !valid_s2 || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign load_s1   = in_valid && !in_stall;
	assign step      = valid_s1 && advance;

	kfi_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	kfi_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.func   (func_s1),
		.now    (now_s1),
		.rx     (rx_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= load_s1 || (valid_s1 && !advance);
			valid_s2 <= step || (valid_s2 && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			func_s1 <= func;
			now_s1  <= now_ms;
			rx_s1   <= rx_byte;
		end
		if (step)
			res_s2 <= res;
	end

	assign out_valid     = valid_s2;
	assign line_action   = res_s2.action;
	assign byte_accepted = res_s2.accepted;
	assign link_state    = res_s2.phase;

endmodule

[src/kfi_checker.sv]
`timescale 1ns / 1ps

module kfi_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] line_action,
	input logic       byte_accepted,
	input logic [2:0] link_state
);
	import kfi_pkg::*;

	// an accepted word is followed by a valid word on the result side
	a_word_through: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##2 out_valid)
		else $error("accepted word did not reach the output");

	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(line_action)
			&& $stable(byte_accepted) && $stable(link_state))
		else $error("stalled result word changed");

	a_send_waits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_action == ACT_SEND |-> link_state == PH_WAITING)
		else $error("start request without waiting phase");

endmodule

bind kline_fast_init_handshake kfi_checker u_kfi_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import kfi_pkg::*;

	localparam int TIME_W = 40;
	localparam int PHASES = 12;
	localparam int WORDS_PER_PHASE = 150;
	localparam int unsigned CYCLE_LIMIT = 300000;

	typedef logic [TIME_W-1:0] ms_t;

	localparam ms_t MS_MAX = '1;
	localparam logic [1:0] FN_UNUSED = 2'd3;
	localparam logic [2:0] CFG_NONE_LO = 3'd6;
	localparam logic [2:0] CFG_NONE_HI = 3'd7;
	// request echo and fixed response, first byte in the low bits
	localparam logic [39:0] ECHO_SEQ = {8'h0C, 8'h81, 8'hF7, 8'h13, 8'h81};
	localparam logic [39:0] REPLY_SEQ = {8'h28, 8'h8F, 8'hD5, 8'hC1, 8'h03};

	class fast_init_board;
		cfg_t cfg;
		phase_t phase;
		logic [2:0] echo_idx;
		logic [2:0] reply_idx;
		logic echo_latched;
		ms_t deadline;
		res_t expected_q[$];
		int fail_count;

		function new();
			cfg.enable = 1'b0;
			cfg.echo_on = 1'b0;
			cfg.low_ms = RST_LOW_MS;
			cfg.high_ms = RST_HIGH_MS;
			cfg.late_ms = RST_LATE_MS;
			cfg.resp_ms = RST_RESP_MS;
			phase = PH_DISABLED;
			echo_idx = '0;
			reply_idx = '0;
			echo_latched = 1'b0;
			deadline = '0;
			fail_count = 0;
		endfunction

		// saturates at the top of the time range
		static function ms_t time_after(ms_t t, logic [15:0] span);
			logic [TIME_W:0] sum;
			sum = {1'b0, t} + span;
			return sum[TIME_W] ? MS_MAX : sum[TIME_W-1:0];
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] data);
			case (idx)
				CFG_ENABLE:  cfg.enable = data[0];
				CFG_ECHO_ON: cfg.echo_on = data[0];
				CFG_LOW_MS:  cfg.low_ms = data[7:0];
				CFG_HIGH_MS: cfg.high_ms = data[7:0];
				CFG_LATE_MS: cfg.late_ms = data[7:0];
				CFG_RESP_MS: cfg.resp_ms = data;
				default: ;
			endcase
		endfunction

		function void note_word(logic [1:0] f, ms_t t, logic [7:0] b);
			action_t act;
			logic acc;
			res_t r;
			act = ACT_NONE;
			acc = 1'b0;
			case (f)
				FN_START: begin
					echo_latched = cfg.echo_on;
					echo_idx = '0;
					reply_idx = '0;
					deadline = time_after(t, 16'(cfg.low_ms));
					if (cfg.enable) begin
						phase = PH_LOW;
						act = ACT_LOW;
					end else begin
						phase = PH_DISABLED;
					end
				end
				FN_TICK: begin
					if (phase == PH_LOW || phase == PH_HIGH) begin
						if (t >= deadline) begin
							if (t - deadline > ms_t'(cfg.late_ms)) begin
								phase = PH_FAILED;
								act = ACT_STOP;
							end else if (phase == PH_LOW) begin
								phase = PH_HIGH;
								deadline = time_after(t, 16'(cfg.high_ms));
								act = ACT_HIGH;
							end else begin
								phase = PH_WAITING;
								deadline = time_after(t, cfg.resp_ms);
								act = ACT_SEND;
							end
						end
					end else if (phase == PH_WAITING && t >= deadline) begin
						phase = PH_FAILED;
						act = ACT_STOP;
					end
				end
				FN_BYTE: begin
					if (phase == PH_WAITING) begin
						if (t >= deadline) begin
							phase = PH_FAILED;
						end else if (echo_latched && echo_idx < MSG_LEN) begin
							if (b == ECHO_SEQ[8*echo_idx +: 8])
								acc = 1'b1;
							else
								phase = PH_FAILED;
							echo_idx++;
						end else if (reply_idx < MSG_LEN) begin
							if (b == REPLY_SEQ[8*reply_idx +: 8]) begin
								acc = 1'b1;
								if (reply_idx == LAST_IDX)
									phase = PH_CONNECTED;
							end else begin
								phase = PH_FAILED;
							end
							reply_idx++;
						end
					end
				end
				default: ;
			endcase
			r.action = act;
			r.accepted = acc;
			r.phase = phase;
			expected_q.push_back(r);
		endfunction

		function void check_word(logic [2:0] act, logic acc, logic [2:0] ph);
			res_t e;
			if (expected_q.size() == 0) begin
				$error("result word with nothing expected");
				fail_count++;
				return;
			end
			e = expected_q.pop_front();
			if (act !== e.action) begin
				$error("line_action: expected %0d, got %0d", e.action, act);
				fail_count++;
			end
			if (acc !== e.accepted) begin
				$error("byte_accepted: expected %0d, got %0d", e.accepted, acc);
				fail_count++;
			end
			if (ph !== e.phase) begin
				$error("link_state: expected %0d, got %0d", e.phase, ph);
				fail_count++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] func;
	ms_t now_ms;
	logic [7:0] rx_byte;
	logic out_valid;
	logic out_stall;
	logic [2:0] line_action;
	logic byte_accepted;
	logic [2:0] link_state;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	fast_init_board board;
	ms_t wall_ms;
	int words_sent;
	int burst_left;
	int unsigned cycles;

	kline_fast_init_handshake #(
		.TIME_BITS(TIME_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.now_ms(now_ms),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.line_action(line_action),
		.byte_accepted(byte_accepted),
		.link_state(link_state),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	// receiver stall pattern, switching between four modes at random
	initial begin : result_stall
		int stall_mode;
		int stall_left;
		stall_mode = 0;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(20, 300);
			end
			stall_left--;
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= (stall_left % 5) < 2;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				board.note_word(func, now_ms, rx_byte);
			if (out_valid && !out_stall)
				board.check_word(line_action, byte_accepted, link_state);
		end
	end

	task automatic push_word(logic [1:0] f, ms_t t, logic [7:0] b);
		int gap;
		in_valid <= 1'b1;
		func <= f;
		now_ms <= t;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.write_reg(idx, data);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_ms8();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd255;
			default: return 8'($urandom_range(1, 60));
		endcase
	endfunction

	task automatic choose_setting(int p);
		logic en;
		logic ec;
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] tl;
		logic [15:0] rs;
		logic [15:0] junk;
		en = ($urandom_range(0, 7) != 0);
		ec = 1'($urandom);
		lo = pick_ms8();
		hi = pick_ms8();
		tl = pick_ms8();
		case ($urandom_range(0, 4))
			0: rs = 16'd1;
			1: rs = 16'hFFFF;
			2: rs = 16'($urandom);
			default: rs = 16'($urandom_range(20, 2000));
		endcase
		case (p)
			0: begin
				en = 1'b1; ec = 1'b1; lo = 8'd0; hi = 8'd0; tl = 8'd0; rs = 16'd1;
			end
			1: begin
				en = 1'b1; ec = 1'b0; lo = 8'd255; hi = 8'd255; tl = 8'd255; rs = 16'hFFFF;
			end
			2: en = 1'b0;
			3: begin
				en = 1'b1; ec = 1'b1; lo = 8'd1; hi = 8'd1; rs = 16'd200;
			end
			default: ;
		endcase
		settle();
		junk = 16'($urandom);
		write_reg(CFG_ENABLE, {junk[15:1], en});
		junk = 16'($urandom);
		write_reg(CFG_ECHO_ON, {junk[15:1], ec});
		junk = 16'($urandom);
		write_reg(CFG_LOW_MS, {junk[15:8], lo});
		junk = 16'($urandom);
		write_reg(CFG_HIGH_MS, {junk[15:8], hi});
		junk = 16'($urandom);
		write_reg(CFG_LATE_MS, {junk[15:8], tl});
		write_reg(CFG_RESP_MS, rs);
		write_reg($urandom_range(0, 1) ? CFG_NONE_HI : CFG_NONE_LO, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// one timed pulse: up to two early ticks and at times a stray byte, then the deadline tick, on time or late
	task automatic drive_pulse(ms_t dl, output bit ok);
		ms_t tick;
		int n;
		if (dl > wall_ms) begin
			n = $urandom_range(0, 2);
			repeat (n)
				push_word(FN_TICK,
					wall_ms + ms_t'($urandom_range(0, int'(dl - wall_ms) - 1)),
					8'($urandom));
		end
		if ($urandom_range(0, 9) == 0)
			push_word(FN_BYTE, wall_ms, 8'($urandom));
		if ($urandom_range(0, 6) == 0)
			tick = fast_init_board::time_after(dl,
				16'(board.cfg.late_ms + 1 + $urandom_range(0, 30)));
		else
			tick = fast_init_board::time_after(dl,
				16'($urandom_range(0, board.cfg.late_ms)));
		push_word(FN_TICK, tick, 8'($urandom));
		ok = (tick - dl) <= ms_t'(board.cfg.late_ms);
		wall_ms = tick;
	endtask

	task automatic run_handshake();
		ms_t dl;
		bit ok;
		logic [7:0] want;
		int total;
		int r;
		case ($urandom_range(0, 19))
			0: wall_ms = MS_MAX - ms_t'($urandom_range(0, 300));
			1: wall_ms = ms_t'({$urandom, $urandom});
			default: wall_ms = wall_ms + ms_t'($urandom_range(0, 50));
		endcase
		push_word(FN_START, wall_ms, 8'($urandom));
		if (!board.cfg.enable)
			return;
		drive_pulse(fast_init_board::time_after(wall_ms, 16'(board.cfg.low_ms)), ok);
		if (!ok)
			return;
		drive_pulse(fast_init_board::time_after(wall_ms, 16'(board.cfg.high_ms)), ok);
		if (!ok)
			return;
		dl = fast_init_board::time_after(wall_ms, board.cfg.resp_ms);
		total = board.cfg.echo_on ? 10 : 5;
		for (int i = 0; i < total; i++) begin
			want = (total == 10 && i < 5) ? ECHO_SEQ[8*i +: 8] : REPLY_SEQ[8*(i % 5) +: 8];
			r = $urandom_range(0, 99);
			if (r < 3) begin
				push_word(FN_TICK, fast_init_board::time_after(dl, 16'($urandom_range(0, 5))),
					8'($urandom));
				return;
			end
			if (r < 5) begin
				push_word(FN_BYTE, fast_init_board::time_after(dl, 16'($urandom_range(0, 5))),
					want);
				return;
			end
			if (r < 9) begin
				push_word(FN_BYTE, wall_ms, want ^ 8'($urandom_range(1, 255)));
				return;
			end
			if (r < 11)
				return;
			if (r < 20)
				push_word(FN_TICK, wall_ms, 8'($urandom));
			if (board.cfg.resp_ms > 40)
				wall_ms = wall_ms + ms_t'($urandom_range(0, 3));
			push_word(FN_BYTE, wall_ms, want);
		end
		repeat ($urandom_range(0, 2))
			push_word(2'($urandom_range(1, 3)), wall_ms + ms_t'($urandom_range(0, 9)),
				8'($urandom));
	endtask

	initial begin
		int target;
		board = new();
		wall_ms = '0;
		words_sent = 0;
		burst_left = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		func <= FN_START;
		now_ms <= '0;
		rx_byte <= 8'h00;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_ENABLE;
		cfg_data <= 16'h0000;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disabled at reset: start, tick, byte and unknown kind all leave it idle
		push_word(FN_START, '0, 8'h00);
		push_word(FN_TICK, MS_MAX, 8'hFF);
		push_word(FN_BYTE, 40'd40, REPLY_SEQ[7:0]);
		push_word(FN_UNUSED, MS_MAX, 8'hFF);
		settle();
		write_reg(CFG_ENABLE, 16'h0001);
		cfg_valid <= 1'b0;

		// deadlines saturating at the top of the time range, byte after timeout
		push_word(FN_START, MS_MAX - 40'd10, 8'h00);
		push_word(FN_TICK, MS_MAX, 8'h00);
		push_word(FN_TICK, MS_MAX, 8'h00);
		push_word(FN_BYTE, MS_MAX, REPLY_SEQ[7:0]);
		// lateness exactly at tolerance, then one past it
		push_word(FN_START, '0, 8'h00);
		push_word(FN_TICK, 40'd24, 8'h00);
		push_word(FN_TICK, 40'd35, 8'h00);
		push_word(FN_TICK, 40'd71, 8'h00);
		push_word(FN_TICK, 40'd72, 8'h00);
		// clean run to connected, with stray bytes outside waiting
		push_word(FN_START, 40'd100, 8'h00);
		push_word(FN_TICK, 40'd125, 8'h00);
		push_word(FN_BYTE, 40'd126, REPLY_SEQ[7:0]);
		push_word(FN_TICK, 40'd150, 8'h00);
		for (int i = 0; i < 5; i++)
			push_word(FN_BYTE, 40'd151 + 40'(i), REPLY_SEQ[8*i +: 8]);
		push_word(FN_BYTE, 40'd156, REPLY_SEQ[7:0]);
		push_word(FN_TICK, 40'd2000, 8'h00);
		// restart from connected, then a very late tick
		push_word(FN_START, 40'd200, 8'h00);
		push_word(FN_TICK, 40'd3000, 8'h00);
		wall_ms = 40'd4000;

		for (int p = 0; p < PHASES; p++) begin
			choose_setting(p);
			target = words_sent + WORDS_PER_PHASE;
			while (words_sent < target) begin
				if ($urandom_range(0, 9) < 8)
					run_handshake();
				else
					push_word(2'($urandom),
						$urandom_range(0, 1) ? ms_t'({$urandom, $urandom}) : wall_ms,
						8'($urandom));
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (board.fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[kline_fast_init_handshake.f]
src/kfi_pkg.sv
src/kfi_cfg.sv
src/kfi_core.sv
src/kline_fast_init_handshake.sv
src/kfi_checker.sv
tb/testbench.sv
